FILE: rtl/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants of the RTMP chunk packetizer: item structs,
// command format between front and back, register indexes, header layout.
// ----------------------------------------------------------------------------
package rcp_pkg;

  // Type-0 chunk header length on the wire
  localparam int unsigned HEADER_BYTES = 12;
  // Extended timestamp field length
  localparam int unsigned EXT_BYTES    = 4;
  // Payload command slots: type-3 byte, four timestamp bytes, data byte
  localparam int unsigned PAY_SLOTS    = 1 + EXT_BYTES + 1;
  localparam int unsigned SLOT_W       = $clog2(HEADER_BYTES);
  localparam int unsigned NBYTES_W     = $clog2(HEADER_BYTES + 1);
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [23:0] EXT_MARK       = 24'hFFFFFF;
  localparam logic [5:0]  CS_LOW         = 6'd2;
  localparam logic [23:0] CHUNK_SIZE_RST = 24'd128;
  localparam logic [1:0]  FMT_TYPE0      = 2'b00;
  localparam logic [1:0]  FMT_TYPE3      = 2'b11;
  localparam logic        REQ_HEADER     = 1'b0;

  localparam logic [SLOT_W-1:0] SLOT_TYPE3    = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_EXT0     = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_DATA     = SLOT_W'(PAY_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_HDR_LAST = SLOT_W'(HEADER_BYTES - 1);

  typedef enum logic [0:0] {
    CFG_CHUNK_SIZE = 1'b0,
    CFG_ACK_WINDOW = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_HEADER  = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_ERROR   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  msg_type;
    logic [31:0] stream_id;
    logic [31:0] msg_stamp;
    logic [5:0]  chunk_stream;
    logic [23:0] body_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        message_done;
    logic        ack_due;
    logic [31:0] ack_value;
    logic        bad_chunk_id;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [5:0]  chunk_stream;
    logic [31:0] stamp;
    logic        ext;
    logic        boundary;
    logic [7:0]  msg_type;
    logic [31:0] stream_id;
    logic [23:0] body_length;
    logic [7:0]  data_byte;
    logic        finish;
    logic        ack_due;
    logic [31:0] ack_value;
  } cmd_t;

endpackage

FILE: rtl/rcp_front.sv
// ----------------------------------------------------------------------------
// rcp_front
// Accepts items, tracks message and chunk state and byte totals, and turns
// each header and open-message payload item into one sequencer command.
// ----------------------------------------------------------------------------
module rcp_front
  import rcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [23:0] chunk_size_i,
  input  logic [31:0] ack_window_i,
  input  logic        in_valid_i,
  input  in_item_t    in_item_i,
  output logic        in_ready_o,
  output logic        push_o,
  output cmd_t        cmd_o,
  input  logic        push_ready_i
);

  logic        active_q, active_d;
  logic        ext_q, ext_d;
  logic [31:0] stamp_q, stamp_d;
  logic [5:0]  cs_q, cs_d;
  logic        started_q, started_d;
  logic [23:0] fill_q, fill_d;
  logic [23:0] remain_q, remain_d;
  // total_sent plus bytes of the open message
  logic [31:0] run_total_q, run_total_d;
  // run_total minus total at the last acknowledgement
  logic [31:0] since_ack_q, since_ack_d;

  logic                accept;
  logic [23:0]         limit;
  logic                boundary;
  logic [23:0]         fill_base;
  logic                ext_now;
  logic                finish;
  logic                ack;
  logic [NBYTES_W-1:0] nbytes;
  logic [31:0]         run_new;
  logic [31:0]         since_new;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  assign limit     = (chunk_size_i == '0) ? 24'd1 : chunk_size_i;
  assign boundary  = started_q && (fill_q >= limit);
  assign fill_base = boundary ? '0 : fill_q;
  assign ext_now   = ext_q && (fill_base == '0);

  always_comb begin
    active_d  = active_q;
    ext_d     = ext_q;
    stamp_d   = stamp_q;
    cs_d      = cs_q;
    started_d = started_q;
    fill_d    = fill_q;
    remain_d  = remain_q;
    push_o    = 1'b0;
    finish    = 1'b0;
    nbytes    = '0;
    cmd_o     = '0;
    cmd_o.kind = CMD_HEADER;

    if (accept) begin
      if (in_item_i.req_type == REQ_HEADER) begin
        // a new header abandons any open message; its bytes stay counted
        push_o = 1'b1;
        if (in_item_i.chunk_stream < CS_LOW) begin
          cmd_o.kind = CMD_ERROR;
          active_d   = 1'b0;
        end else begin
          ext_d     = in_item_i.msg_stamp >= 32'(EXT_MARK);
          stamp_d   = in_item_i.msg_stamp;
          cs_d      = in_item_i.chunk_stream;
          started_d = 1'b0;
          fill_d    = '0;
          remain_d  = in_item_i.body_length;
          finish    = (in_item_i.body_length == '0);
          active_d  = !finish;
          nbytes    = NBYTES_W'(HEADER_BYTES);

          cmd_o.kind         = CMD_HEADER;
          cmd_o.chunk_stream = in_item_i.chunk_stream;
          cmd_o.stamp        = in_item_i.msg_stamp;
          cmd_o.ext          = ext_d;
          cmd_o.msg_type     = in_item_i.msg_type;
          cmd_o.stream_id    = in_item_i.stream_id;
          cmd_o.body_length  = in_item_i.body_length;
        end
      end else if (active_q) begin
        push_o    = 1'b1;
        fill_d    = fill_base + 24'd1;
        started_d = 1'b1;
        remain_d  = remain_q - 24'd1;
        finish    = (remain_q == 24'd1);
        active_d  = !finish;
        nbytes    = NBYTES_W'(1) + NBYTES_W'(boundary)
                  + (ext_now ? NBYTES_W'(EXT_BYTES) : '0);

        cmd_o.kind         = CMD_PAYLOAD;
        cmd_o.chunk_stream = cs_q;
        cmd_o.stamp        = stamp_q;
        cmd_o.ext          = ext_now;
        cmd_o.boundary     = boundary;
        cmd_o.data_byte    = in_item_i.data_byte;
      end
    end

    run_new   = run_total_q + 32'(nbytes);
    since_new = since_ack_q + 32'(nbytes);
    ack       = finish && (ack_window_i != '0) && (since_new >= ack_window_i);

    run_total_d = run_new;
    since_ack_d = ack ? '0 : since_new;

    cmd_o.finish    = finish;
    cmd_o.ack_due   = ack;
    cmd_o.ack_value = ack ? run_new : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      ext_q       <= 1'b0;
      stamp_q     <= '0;
      cs_q        <= '0;
      started_q   <= 1'b0;
      fill_q      <= '0;
      remain_q    <= '0;
      run_total_q <= '0;
      since_ack_q <= '0;
    end else begin
      active_q    <= active_d;
      ext_q       <= ext_d;
      stamp_q     <= stamp_d;
      cs_q        <= cs_d;
      started_q   <= started_d;
      fill_q      <= fill_d;
      remain_q    <= remain_d;
      run_total_q <= run_total_d;
      since_ack_q <= since_ack_d;
    end
  end

endmodule

FILE: rtl/rcp_queue.sv
// ----------------------------------------------------------------------------
// rcp_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module rcp_queue
  import rcp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/rcp_back.sv
// ----------------------------------------------------------------------------
// rcp_back
// Byte sequencer: walks each command's slots, one wire word per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module rcp_back
  import rcp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned HDR_W = HEADER_BYTES * 8;
  localparam int unsigned PAY_W = PAY_SLOTS * 8;

  logic              mid_q;
  logic [SLOT_W-1:0] slot_q;
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic              advance;
  logic [SLOT_W-1:0] start_slot;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] next_slot;
  logic              is_last;
  logic [23:0]       ts24;
  logic [HDR_W-1:0]  hdr_word;
  logic [HDR_W-1:0]  hdr_shift;
  logic [PAY_W-1:0]  pay_word;
  logic [PAY_W-1:0]  pay_shift;
  out_item_t         item;

  assign advance = cmd_valid_i && (!out_valid_q || out_ready_i);
  // payload skips the type-3 byte and the timestamp bytes it does not need
  assign start_slot = (cmd_i.kind != CMD_PAYLOAD) ? '0 :
                      cmd_i.boundary ? SLOT_TYPE3 : (cmd_i.ext ? SLOT_EXT0 : SLOT_DATA);
  assign cur     = mid_q ? slot_q : start_slot;

  assign ts24     = cmd_i.ext ? EXT_MARK : cmd_i.stamp[23:0];
  // stream id goes out little endian
  assign hdr_word = {FMT_TYPE0, cmd_i.chunk_stream, ts24, cmd_i.body_length,
                     cmd_i.msg_type, cmd_i.stream_id[7:0], cmd_i.stream_id[15:8],
                     cmd_i.stream_id[23:16], cmd_i.stream_id[31:24]};
  assign pay_word = {FMT_TYPE3, cmd_i.chunk_stream, cmd_i.stamp, cmd_i.data_byte};
  assign hdr_shift = hdr_word << {cur, 3'b000};
  assign pay_shift = pay_word << {cur, 3'b000};

  always_comb begin
    next_slot  = cur + SLOT_W'(1);
    is_last    = 1'b1;
    item       = '0;
    unique case (cmd_i.kind)
      CMD_HEADER: begin
        is_last         = (cur == SLOT_HDR_LAST);
        item.out_byte   = hdr_shift[HDR_W-1 -: 8];
        item.byte_valid = 1'b1;
      end
      CMD_PAYLOAD: begin
        if (cur == SLOT_TYPE3) begin
          next_slot = cmd_i.ext ? SLOT_EXT0 : SLOT_DATA;
        end
        is_last         = (cur == SLOT_DATA);
        item.out_byte   = pay_shift[PAY_W-1 -: 8];
        item.byte_valid = 1'b1;
      end
      CMD_ERROR: begin
        item.bad_chunk_id = 1'b1;
      end
      default: begin
        item.bad_chunk_id = 1'b1;
      end
    endcase
    item.run_last = is_last;
    if (is_last && cmd_i.finish) begin
      item.message_done = 1'b1;
      item.ack_due      = cmd_i.ack_due;
      item.ack_value    = cmd_i.ack_value;
    end
  end

  assign pop_o       = advance && is_last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q       <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        mid_q       <= !is_last;
        slot_q      <= next_slot;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/rtmp_chunk_packetizer.sv
// ----------------------------------------------------------------------------
// rtmp_chunk_packetizer
// Splits RTMP messages into a chunked byte stream with type-0 and type-3
// chunk headers, extended timestamps and acknowledgement flagging.
// ----------------------------------------------------------------------------
// Send a header item to open a message, then body_length payload-byte items.
// A header with a chunk stream id of 0 or 1 gives one word with bad_chunk_id
// set and closes the message; payload bytes with no open message are dropped
// without any word. Each header gives 12 words (the type-0 chunk header);
// each payload byte gives one word, plus one type-3 basic byte when it opens
// a new chunk, plus four timestamp bytes when the timestamp is extended and
// the byte opens a chunk. run_last marks the last word of one item,
// message_done the last word of a message, where ack_due and ack_value report
// an acknowledgement when the window is reached. The front takes one item
// per cycle while the two-entry command queue has room; the back sequencer
// emits one word per cycle while the output is not stalled.
// Write chunk_size (index 0) and ack_window (index 1) only while idle.
module rtmp_chunk_packetizer
  import rcp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  logic [23:0] chunk_size_q;
  logic [31:0] ack_window_q;

  logic        push;
  logic        push_ready;
  cmd_t        push_cmd;
  logic        cmd_valid;
  cmd_t        cmd;
  logic        pop;

  // Configuration registers: plain writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= CHUNK_SIZE_RST;
      ack_window_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHUNK_SIZE: chunk_size_q <= cfg_data_i[23:0];
        CFG_ACK_WINDOW: ack_window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: classify items, advance chunk state and byte totals
  rcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chunk_size_i (chunk_size_q),
    .ack_window_i (ack_window_q),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .push_ready_i (push_ready)
  );

  // Hold commands so front and back stall on their own
  rcp_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (push_ready),
    .valid_o (cmd_valid),
    .cmd_o   (cmd),
    .pop_i   (pop)
  );

  // Back: expand each command into wire words
  rcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/rcp_checker.sv
// ----------------------------------------------------------------------------
// rcp_checker
// Port-level checks of the packetizer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module rcp_checker
  import rcp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a word that is not last of its item is followed at once by the next one
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.run_last |=> out_valid_o)
    else $error("word run broken inside one item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output word changed");

  a_ack_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.ack_due |->
      out_item_o.message_done && out_item_o.run_last && out_item_o.byte_valid)
    else $error("ack flagged away from message end");

  a_bad_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bad_chunk_id |->
      out_item_o.run_last && !out_item_o.byte_valid && !out_item_o.message_done)
    else $error("bad chunk id word malformed");

endmodule

bind rtmp_chunk_packetizer rcp_checker u_checker (.*);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb - RTMP chunk packetizer testbench
// Feeds message headers and payload bytes through the packetizer, predicts
// every wire word with an independent packetizing model and checks each
// output word field by field, under random bursts, stalls and a long hold.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcp_pkg::*;

  localparam logic REQ_BYTE      = ~REQ_HEADER;
  // Cycles to let the block run dry after the last expected word
  localparam int   SETTLE_CYCLES = 24;
  // Long receiver hold, enough to fill the command queue and stall the input
  localparam int   HOLD_CYCLES   = 400;
  localparam int   REPORT_LIMIT  = 10;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_MOSTLY,
    READY_RARELY
  } ready_mode_e;

  // One directed row: the item and, where pinned, the first word it must give
  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t word;
  } plan_row_t;

  typedef struct {
    bit        on;
    out_item_t word;
  } pin_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;

  rtmp_chunk_packetizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Packetizing model: its own copy of the registers and the message state.
  // Reset is applied once, so the declared values are the reset state.
  // --------------------------------------------------------------------------
  logic [23:0] size_reg    = CHUNK_SIZE_RST;
  logic [31:0] window_reg  = '0;
  logic [31:0] sent_total  = '0;
  logic [31:0] sent_at_ack = '0;
  logic [31:0] msg_bytes   = '0;
  logic [23:0] offset      = '0;
  logic [23:0] left        = '0;
  logic [23:0] fill        = '0;
  logic [5:0]  open_cs     = '0;
  logic [31:0] stamp_full  = '0;
  logic        stamp_ext   = 1'b0;
  logic        msg_open    = 1'b0;

  // Wire words still owed by the block, oldest first
  out_item_t wire_words_q[$];
  // Pinned first words, one entry per offered item, in offer order
  pin_t      pins_q[$];

  int fault_count   = 0;
  // Accepted items that gave at least one word
  int busy_items    = 0;
  int burst_left    = 0;
  // Payload bytes the stimulus believes the open message still wants
  int bytes_owed    = 0;
  bit hold_off_req  = 1'b0;

  function automatic void emit_byte(input logic [7:0] b);
    out_item_t w;
    w = '0;
    w.out_byte   = b;
    w.byte_valid = 1'b1;
    wire_words_q.push_back(w);
    msg_bytes = msg_bytes + 32'd1;
  endfunction

  // Mark the newest word as the end of the message and run the ack check
  function automatic void close_message();
    out_item_t   w;
    logic [31:0] since;
    w = wire_words_q.pop_back();
    sent_total = sent_total + msg_bytes;
    msg_bytes  = '0;
    msg_open   = 1'b0;
    w.message_done = 1'b1;
    since = sent_total - sent_at_ack;
    if (window_reg != '0 && since >= window_reg) begin
      sent_at_ack = sent_total;
      w.ack_due   = 1'b1;
      w.ack_value = sent_total;
    end
    wire_words_q.push_back(w);
  endfunction

  // Append the words one accepted item gives; return how many
  function automatic int packetize(input in_item_t it);
    int          start;
    logic [23:0] limit;
    logic [23:0] stamp24;
    out_item_t   w;
    start = wire_words_q.size();
    if (it.req_type == REQ_HEADER) begin
      // Abandon an open message: count its bytes, skip the ack check
      if (msg_open) begin
        sent_total = sent_total + msg_bytes;
        msg_open   = 1'b0;
      end
      msg_bytes = '0;
      if (it.chunk_stream < CS_LOW) begin
        w = '0;
        w.bad_chunk_id = 1'b1;
        wire_words_q.push_back(w);
      end else begin
        stamp_ext  = it.msg_stamp >= {8'h00, EXT_MARK};
        stamp_full = it.msg_stamp;
        open_cs    = it.chunk_stream;
        offset     = '0;
        fill       = '0;
        left       = it.body_length;
        msg_open   = 1'b1;
        stamp24    = stamp_ext ? EXT_MARK : it.msg_stamp[23:0];
        emit_byte({FMT_TYPE0, it.chunk_stream});
        emit_byte(stamp24[23:16]);
        emit_byte(stamp24[15:8]);
        emit_byte(stamp24[7:0]);
        emit_byte(it.body_length[23:16]);
        emit_byte(it.body_length[15:8]);
        emit_byte(it.body_length[7:0]);
        emit_byte(it.msg_type);
        emit_byte(it.stream_id[7:0]);
        emit_byte(it.stream_id[15:8]);
        emit_byte(it.stream_id[23:16]);
        emit_byte(it.stream_id[31:24]);
        // Empty body: the header closes the message, no timestamp bytes
        if (it.body_length == '0) close_message();
      end
    end else begin
      if (!msg_open) return 0;
      limit = (size_reg == '0) ? 24'd1 : size_reg;
      // Open a new chunk once the current one is full (also after a shrink)
      if (offset != '0 && fill >= limit) begin
        emit_byte({FMT_TYPE3, open_cs});
        fill = '0;
      end
      if (fill == '0 && stamp_ext) begin
        emit_byte(stamp_full[31:24]);
        emit_byte(stamp_full[23:16]);
        emit_byte(stamp_full[15:8]);
        emit_byte(stamp_full[7:0]);
      end
      emit_byte(it.data_byte);
      fill   = fill + 24'd1;
      offset = offset + 24'd1;
      left   = left - 24'd1;
      if (left == '0) close_message();
    end
    w = wire_words_q.pop_back();
    w.run_last = 1'b1;
    wire_words_q.push_back(w);
    return wire_words_q.size() - start;
  endfunction

  task automatic flag_fault(input string why, input out_item_t want, input out_item_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected byte %h v%b last %b done %b ack %b %h bad %b", $realtime,
               why, want.out_byte, want.byte_valid, want.run_last, want.message_done,
               want.ack_due, want.ack_value, want.bad_chunk_id);
      $display("%0t %s: actual   byte %h v%b last %b done %b ack %b %h bad %b", $realtime,
               why, got.out_byte, got.byte_valid, got.run_last, got.message_done,
               got.ack_due, got.ack_value, got.bad_chunk_id);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict on each accepted item, then check
  // each accepted word. Everything is sampled at the same edge, so the
  // prediction always lands before a word it could be compared with.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : wire_watch
    int        made;
    int        base;
    pin_t      pin;
    out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CHUNK_SIZE) size_reg = cfg_data_i[23:0];
        else window_reg = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        pin  = pins_q.pop_front();
        base = wire_words_q.size();
        made = packetize(in_item_i);
        if (made > 0) begin
          busy_items++;
          // Hold the typed-in word in place of the predicted first word
          if (pin.on) wire_words_q[base] = pin.word;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (wire_words_q.size() == 0) begin
          flag_fault("unexpected word", '0, out_item_o);
        end else begin
          want = wire_words_q.pop_front();
          if (out_item_o.out_byte !== want.out_byte ||
              out_item_o.byte_valid !== want.byte_valid ||
              out_item_o.run_last !== want.run_last ||
              out_item_o.message_done !== want.message_done ||
              out_item_o.ack_due !== want.ack_due ||
              out_item_o.ack_value !== want.ack_value ||
              out_item_o.bad_chunk_id !== want.bad_chunk_id)
            flag_fault("word mismatch", want, out_item_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offer one item in bursts of random length, with random gaps.
  // Drop valid only when a real gap follows, so it never dips within a step.
  // --------------------------------------------------------------------------
  task automatic offer(input in_item_t it, input bit pinned, input out_item_t pin_word);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pins_q.push_back(pin_t'{pinned, pin_word});
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // Go idle: wait for every owed word, then let the pipeline run dry
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (wire_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back cycles; junk fills the unused top byte
  task automatic set_regs(input logic [23:0] size, input logic [31:0] window,
                          input logic [7:0] junk);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CHUNK_SIZE;
    cfg_data_i <= {junk, size};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ACK_WINDOW;
    cfg_data_i <= window;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic in_item_t hdr_item(input logic [7:0] mt, input logic [31:0] sid,
                                        input logic [31:0] ts, input logic [5:0] cs,
                                        input logic [23:0] len);
    in_item_t it;
    it = '0;
    it.req_type     = REQ_HEADER;
    it.msg_type     = mt;
    it.stream_id    = sid;
    it.msg_stamp    = ts;
    it.chunk_stream = cs;
    it.body_length  = len;
    return it;
  endfunction

  function automatic in_item_t byte_item(input logic [7:0] b);
    in_item_t it;
    it = '0;
    it.req_type  = REQ_BYTE;
    it.data_byte = b;
    return it;
  endfunction

  // Mostly well-formed messages with random content; some stray bytes,
  // rejected ids and headers that cut a message short.
  function automatic in_item_t next_item();
    in_item_t it;
    int       pick;
    it.msg_type     = 8'($urandom);
    it.stream_id    = $urandom;
    it.msg_stamp    = $urandom;
    it.chunk_stream = 6'($urandom);
    it.body_length  = 24'($urandom);
    it.data_byte    = 8'($urandom);
    pick = $urandom_range(0, 99);
    if ((bytes_owed != 0 && pick < 92) || (bytes_owed == 0 && pick < 12)) begin
      it.req_type = REQ_BYTE;
      if (bytes_owed != 0) bytes_owed--;
    end else begin
      it.req_type     = REQ_HEADER;
      it.chunk_stream = ($urandom_range(0, 11) == 0) ? 6'($urandom_range(0, 1))
                                                     : 6'($urandom_range(2, 63));
      case ($urandom_range(0, 9))
        0:       it.body_length = '0;
        1:       it.body_length = 24'($urandom);
        2:       it.body_length = 24'($urandom_range(25, 90));
        default: it.body_length = 24'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        4, 5, 6, 7: it.msg_stamp = 32'($urandom_range(0, 32'h00FFFFFE));
        8:          it.msg_stamp = {8'h00, EXT_MARK};
        9:          it.msg_stamp = 32'h00FFFFFE;
        default:    it.msg_stamp = $urandom;
      endcase
      bytes_owed = (it.chunk_stream < CS_LOW) ? 0 : int'(it.body_length);
    end
    return it;
  endfunction

  // Offer random items until n more have given words, then go idle
  task automatic run_random(input int n);
    int target;
    target = busy_items + n;
    while (busy_items < target) offer(next_item(), 1'b0, '0);
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, segment by segment; on request,
  // hold off for a long stretch so the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int          seg;
    ready_mode_e mode;
    out_ready_i = 1'b0;
    forever begin
      seg  = $urandom_range(8, 120);
      mode = ready_mode_e'($urandom_range(0, 3));
      repeat (seg) begin
        @(posedge clk_i);
        if (hold_off_req) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_off_req = 1'b0;
        end
        case (mode)
          READY_ALWAYS: out_ready_i <= 1'b1;
          READY_HALF:   out_ready_i <= ($urandom_range(0, 1) == 1);
          READY_MOSTLY: out_ready_i <= ($urandom_range(0, 7) != 0);
          default:      out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan[$];
    out_item_t lead_word;
    out_item_t reject_word;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_CHUNK_SIZE;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Basic byte of a type-0 header on chunk stream 2, and the reject word
    lead_word   = '{8'h02, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0};
    reject_word = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1};

    // Directed pass: four-byte chunks so boundaries come quickly, ack at 40
    set_regs(24'd4, 32'd40, 8'h00);
    // stray byte with no open message: dropped, no word
    plan.push_back(plan_row_t'{byte_item(8'hA5), 1'b0, '0});
    // empty body on the lowest id: header alone closes the message
    plan.push_back(plan_row_t'{hdr_item(8'h00, 32'h0, 32'h0, 6'd2, 24'd0), 1'b1, lead_word});
    // top field values, stamp one below the extended mark, a chunk boundary
    plan.push_back(plan_row_t'{hdr_item(8'hFF, 32'hFFFF_FFFF, 32'h00FF_FFFE, 6'd63, 24'd5),
                               1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h00), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'hFF), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h5A), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'hC3), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h80), 1'b0, '0});
    // stamp exactly at the mark: extended bytes on every chunk, first ack
    plan.push_back(plan_row_t'{hdr_item(8'h14, 32'h1, 32'h00FF_FFFF, 6'd3, 24'd5), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h11), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h22), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h33), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h44), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h55), 1'b0, '0});
    // rejected ids; bytes after a rejected header are dropped
    plan.push_back(plan_row_t'{hdr_item(8'h08, 32'h0, 32'hFFFF_FFFF, 6'd0, 24'd3),
                               1'b1, reject_word});
    plan.push_back(plan_row_t'{byte_item(8'h66), 1'b0, '0});
    plan.push_back(plan_row_t'{hdr_item(8'h09, 32'h0, 32'h0, 6'd1, 24'd3), 1'b1, reject_word});
    // message cut short by the next header
    plan.push_back(plan_row_t'{hdr_item(8'h12, 32'h1234_5678, 32'h8000_0000, 6'd40, 24'd10),
                               1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h77), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h88), 1'b0, '0});
    plan.push_back(plan_row_t'{hdr_item(8'h01, 32'h2, 32'd100, 6'd7, 24'd2), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'h99), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'hAA), 1'b0, '0});
    // longest body, left open for the random part to carry on
    plan.push_back(plan_row_t'{hdr_item(8'h04, 32'h0, 32'h0, 6'd2, 24'hFF_FFFF), 1'b0, '0});
    plan.push_back(plan_row_t'{byte_item(8'hBB), 1'b0, '0});
    foreach (plan[i]) offer(plan[i].item, plan[i].pinned, plan[i].word);
    settle();

    // Smallest chunk, ack at the end of every message
    set_regs(24'd1, 32'd1, 8'h00);
    run_random(70);
    // Zero chunk size acts as one; zero window turns acks off
    set_regs(24'd0, 32'd0, 8'hFF);
    run_random(50);
    // Largest chunk and a window that is never reached
    set_regs(24'hFF_FFFF, 32'hFFFF_FFFF, 8'h00);
    run_random(60);

    // Mid sizes; hold the receiver off early so the input backs up
    set_regs(24'($urandom_range(6, 16)), 32'($urandom_range(1, 300)), 8'($urandom));
    hold_off_req = 1'b1;
    run_random(110);

    // Leave a partly filled chunk open, then shrink the chunk size under it
    bytes_owed = 0;
    offer(hdr_item(8'($urandom), $urandom, 32'($urandom_range(0, 5000)), 6'd9, 24'd40),
          1'b0, '0);
    repeat (20) offer(byte_item(8'($urandom)), 1'b0, '0);
    settle();
    set_regs(24'd2, 32'd64, 8'h00);
    bytes_owed = 20;
    run_random(80);

    if (fault_count == 0 && wire_words_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/rcp_pkg.sv
rtl/rcp_front.sv
rtl/rcp_queue.sv
rtl/rcp_back.sv
rtl/rtmp_chunk_packetizer.sv
rtl/rcp_checker.sv
dv/tb.sv
